[rtl/core/fapid_pkg.sv]
// Package for the four-axis PID block: field widths, axis codes, per-axis gains,
// and the rounding and clipping helpers used by the datapath (fapid_calc).
// No dependencies.
`default_nettype none

package fapid_pkg;

   localparam int IN_W     = 24;                // Q11.12 input fields
   localparam int ERR_W    = IN_W + 1;          // measured - setpoint
   localparam int DATA_W   = 32;                // Q19.12 integrator and drive
   localparam int AXIS_W   = 2;
   localparam int NUM_AXES = 1 << AXIS_W;
   localparam int GAIN_W   = 30;                // signed gains, 24 fraction bits
   localparam int GAIN_FRAC = 24;
   localparam int PROD_W   = GAIN_FRAC + DATA_W; // wide enough for any product
   localparam int ACC_W    = DATA_W + 3;        // sum of three terms, no wrap

   localparam logic [AXIS_W-1:0] AXIS_ROLL       = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_PITCH      = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_YAW        = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_COLLECTIVE = 2'd3;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic [AXIS_W-1:0]        func;
      logic signed [IN_W-1:0]   measured;
      logic signed [IN_W-1:0]   measured_rate;
      logic signed [IN_W-1:0]   setpoint;
   } req_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;   // integral gain times the 0.02 s period
      logic signed [GAIN_W-1:0] kd;
   } gain_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] val;
   } clip_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] integ;   // updated integrator, already clipped
      logic signed [DATA_W-1:0] drive;
      logic                     sat;
   } calc_type;

   // Sign of each term folded into the gain.
   function automatic gain_type axis_gains(input logic [AXIS_W-1:0] axis);
      gain_type g;
      case (axis)
         AXIS_ROLL: begin
            g.kp = -GAIN_W'(167772160);
            g.ki = -GAIN_W'(6710886);
            g.kd =  GAIN_W'(67108864);
         end
         AXIS_PITCH: begin
            g.kp =  GAIN_W'(201326592);
            g.ki =  GAIN_W'(6710886);
            g.kd =  GAIN_W'(67108864);
         end
         AXIS_YAW: begin
            g.kp = -GAIN_W'(335544320);
            g.ki = -GAIN_W'(8388608);
            g.kd = -GAIN_W'(100663296);
         end
         default: begin   // collective
            g.kp = -GAIN_W'(2516582);
            g.ki = -GAIN_W'(26844);
            g.kd =  GAIN_W'(838861);
         end
      endcase
      return g;
   endfunction

   // Drop GAIN_FRAC bits, round to nearest, ties away from zero.
   // Negative: floor((p + half - 1) / 2^GAIN_FRAC); positive: floor((p + half) / ...).
   function automatic logic signed [DATA_W-1:0] round_gain(
         input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] biased;
      biased = p + ROUND_HALF - PROD_W'(p[PROD_W-1]);
      return $signed(biased[PROD_W-1:GAIN_FRAC]);
   endfunction

   function automatic clip_type clip_data(input logic signed [ACC_W-1:0] x);
      clip_type c;
      if ((x[ACC_W-1:DATA_W-1] == '0) || (x[ACC_W-1:DATA_W-1] == '1)) begin
         c.hit = 1'b0;
         c.val = x[DATA_W-1:0];
      end else begin
         c.hit = 1'b1;
         c.val = x[ACC_W-1] ? DATA_MIN : DATA_MAX;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/fapid_calc.sv]
// Combinational PID update for one item: error, three gain products, integrator
// update and drive, the last two clipped to 32 bits. Depends on fapid_pkg.
`default_nettype none

module fapid_calc (
   input  fapid_pkg::req_type                     item,
   input  logic signed [fapid_pkg::DATA_W-1:0]    integ_cur,
   output fapid_pkg::calc_type                    res
);

   fapid_pkg::gain_type                      g;
   logic signed [fapid_pkg::ERR_W-1:0]       err;
   logic signed [fapid_pkg::PROD_W-1:0]      p_kp;
   logic signed [fapid_pkg::PROD_W-1:0]      p_ki;
   logic signed [fapid_pkg::PROD_W-1:0]      p_kd;
   logic signed [fapid_pkg::DATA_W-1:0]      t_kp;
   logic signed [fapid_pkg::DATA_W-1:0]      t_ki;
   logic signed [fapid_pkg::DATA_W-1:0]      t_kd;
   logic signed [fapid_pkg::ACC_W-1:0]       integ_sum;
   logic signed [fapid_pkg::ACC_W-1:0]       drive_sum;
   fapid_pkg::clip_type                      integ_c;
   fapid_pkg::clip_type                      drive_c;

   always_comb begin
      g    = fapid_pkg::axis_gains(item.func);
      err  = fapid_pkg::ERR_W'(item.measured) - fapid_pkg::ERR_W'(item.setpoint);

      p_kp = fapid_pkg::PROD_W'(err) * fapid_pkg::PROD_W'(g.kp);
      p_ki = fapid_pkg::PROD_W'(err) * fapid_pkg::PROD_W'(g.ki);
      p_kd = fapid_pkg::PROD_W'(item.measured_rate) * fapid_pkg::PROD_W'(g.kd);

      t_kp = fapid_pkg::round_gain(p_kp);
      t_ki = fapid_pkg::round_gain(p_ki);
      t_kd = fapid_pkg::round_gain(p_kd);

      integ_sum = fapid_pkg::ACC_W'(integ_cur) + fapid_pkg::ACC_W'(t_ki);
      integ_c   = fapid_pkg::clip_data(integ_sum);

      drive_sum = fapid_pkg::ACC_W'(t_kp) + fapid_pkg::ACC_W'(integ_c.val)
                + fapid_pkg::ACC_W'(t_kd);
      drive_c   = fapid_pkg::clip_data(drive_sum);

      res.integ = integ_c.val;
      res.drive = drive_c.val;
      res.sat   = integ_c.hit | drive_c.hit;
   end

endmodule

`default_nettype wire

[rtl/core/four_axis_pid_attitude_altitude.sv]
// Top level of the four-axis PID corrector: stream ports, input register,
// per-axis integrators and result register. Depends on fapid_pkg, fapid_calc.
`default_nettype none

// Four PID loops (roll, pitch, yaw, collective altitude) sharing one datapath.
// Each req transfer names an axis in req_tuser and carries measured value, measured
// rate and setpoint (signed Q11.12). With err = measured - setpoint the block adds
// round(err*KI) into that axis's integrator (clipped to 32 bits and stored clipped),
// then returns round(err*KP) + integrator + round(rate*KD), clipped to 32 bits,
// as a signed Q19.12 drive. Gains and their signs are fixed per axis; products are
// rounded to nearest, ties away from zero. rsp_tuser carries the axis and a flag
// that is set when either the integrator or the drive was clipped. Exactly one rsp
// transfer per req transfer, in order. Throughput is one transfer per clock while
// rsp is not stalled; a result passes the input register and then the result
// register before it shows on rsp.
// The rate is set by the integrator read-modify-write, which is done in the one
// compute stage between the input register and the result register, so an item
// for the same axis in the very next cycle sees the updated integrator. Reset
// clears the four integrators to zero and empties both registers.
module four_axis_pid_attitude_altitude (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [23:0] measured, [47:24] measured_rate, [71:48] setpoint
   input  logic [71:0] req_tdata,
   // req_tuser: [1:0] func (axis)
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: [31:0] drive
   output logic [31:0] rsp_tdata,
   // rsp_tuser: [1:0] axis, [2] saturated
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   localparam int DW = fapid_pkg::DATA_W;
   localparam int IW = fapid_pkg::IN_W;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   fapid_pkg::req_type    s1_item_ff,  s1_item_in;

   // integrators, one per axis
   logic signed [DW-1:0]  integ_ff [fapid_pkg::NUM_AXES];

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]  rsp_drive_ff, rsp_drive_in;
   logic [fapid_pkg::AXIS_W-1:0] rsp_axis_ff, rsp_axis_in;
   logic                  rsp_sat_ff,  rsp_sat_in;

   fapid_pkg::calc_type   calc;
   logic                  advance;
   logic                  req_take;

   // item moves from the input register to the result register
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   fapid_calc u_calc (
      .item      (s1_item_ff),
      .integ_cur (integ_ff[s1_item_ff.func]),
      .res       (calc)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_take) begin
         s1_valid_in              = 1'b1;
         s1_item_in.func          = req_tuser;
         s1_item_in.measured      = req_tdata[IW-1:0];
         s1_item_in.measured_rate = req_tdata[2*IW-1:IW];
         s1_item_in.setpoint      = req_tdata[3*IW-1:2*IW];
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = calc.drive;
         rsp_axis_in  = s1_item_ff.func;
         rsp_sat_in   = calc.sat;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_axis_ff  <= rsp_axis_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // integrator write-back happens at the same edge the result is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fapid_pkg::NUM_AXES; i++) begin
            integ_ff[i] <= '0;
         end
      end else if (advance) begin
         integ_ff[s1_item_ff.func] <= calc.integ;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_axis_ff};

endmodule

`default_nettype wire

[rtl/core/fapid_checker.sv]
// Port-level checks for the four-axis PID block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fapid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transfer changed");

   // with the result register empty the block never back-pressures
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low while result register empty");

   // a result out of an idle block comes from an earlier req transfer through the input register
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without matching req transfer");

endmodule

bind four_axis_pid_attitude_altitude fapid_checker u_fapid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
